// ===== design/execution_breakpoint_unit_assert.svh =====
// Assertion helpers for the execution breakpoint unit.
// Both forms sample on clk and are off while arst_n is low.
`ifndef EXECUTION_BREAKPOINT_UNIT_ASSERT_SVH
`define EXECUTION_BREAKPOINT_UNIT_ASSERT_SVH

// same-cycle implication
`define EBU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ebu assertion failed");

// next-cycle implication
`define EBU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ebu assertion failed");

`endif

// ===== design/ebu_pkg.sv =====
package ebu_pkg;

	localparam int BP_ENTRIES = 16;
	localparam int ADDR_BITS  = 24;
	localparam int IDX_W      = (BP_ENTRIES > 1) ? $clog2(BP_ENTRIES) : 1;

	typedef enum logic [3:0] {
		OP_CHECK      = 4'd0,
		OP_ADD        = 4'd1,
		OP_REMOVE     = 4'd2,
		OP_SET_ENABLE = 4'd3,
		OP_CLEAR_ALL  = 4'd4,
		OP_SET_TEMP   = 4'd5,
		OP_CLEAR_TEMP = 4'd6,
		OP_ARM_SKIP   = 4'd7,
		OP_CLEAR_HITS = 4'd8
	} op_t;

	typedef struct packed {
		op_t                  opcode;
		logic [ADDR_BITS-1:0] address;
		logic                 enable_flag;
	} ebu_cmd_t;

	typedef struct packed {
		logic                 break_now;
		logic                 table_full;
		logic                 hit_flag;
		logic [ADDR_BITS-1:0] hit_address;
		logic                 temp_hit;
		logic                 temp_armed;
	} ebu_res_t;

	// table lookup status handed to the control logic
	typedef struct packed {
		logic full;
		logic hit;
		logic any_present;
	} tbl_stat_t;

endpackage

// ===== design/ebu_table.sv =====
module ebu_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  ebu_pkg::ebu_cmd_t   cmd,
	output ebu_pkg::tbl_stat_t  stat
);

	logic [ebu_pkg::ADDR_BITS-1:0] entry_addr_q [ebu_pkg::BP_ENTRIES];
	logic [ebu_pkg::BP_ENTRIES-1:0] present_q;
	logic [ebu_pkg::BP_ENTRIES-1:0] disabled_q;

	logic [ebu_pkg::BP_ENTRIES-1:0] used;
	logic [ebu_pkg::BP_ENTRIES-1:0] match;
	logic                           found;
	logic [ebu_pkg::IDX_W-1:0]      found_idx;
	logic                           free_found;
	logic [ebu_pkg::IDX_W-1:0]      free_idx;
	logic                           no_room;

	// parallel compare; walk downward so the lowest slot wins
	always_comb begin
		used       = present_q | disabled_q;
		found      = 1'b0;
		found_idx  = '0;
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = ebu_pkg::BP_ENTRIES - 1; i >= 0; i--) begin
			match[i] = used[i] && (entry_addr_q[i] == cmd.address);
			if (match[i]) begin
				found     = 1'b1;
				found_idx = ebu_pkg::IDX_W'(i);
			end
			if (!used[i]) begin
				free_found = 1'b1;
				free_idx   = ebu_pkg::IDX_W'(i);
			end
		end
	end

	assign no_room = !found && !free_found;

	always_comb begin
		stat.any_present = |present_q;
		stat.hit         = found && present_q[found_idx] && !disabled_q[found_idx];
		stat.full        = no_room && ((cmd.opcode == ebu_pkg::OP_ADD) ||
			((cmd.opcode == ebu_pkg::OP_SET_ENABLE) && !cmd.enable_flag));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q  <= '0;
			disabled_q <= '0;
		end else if (fire) begin
			unique case (cmd.opcode)
				ebu_pkg::OP_ADD: begin
					if (found) begin
						present_q[found_idx] <= 1'b1;
					end else if (free_found) begin
						present_q[free_idx]  <= 1'b1;
						disabled_q[free_idx] <= 1'b0;
					end
				end
				ebu_pkg::OP_REMOVE: begin
					if (found) begin
						present_q[found_idx]  <= 1'b0;
						disabled_q[found_idx] <= 1'b0;
					end
				end
				ebu_pkg::OP_SET_ENABLE: begin
					if (found) begin
						disabled_q[found_idx] <= !cmd.enable_flag;
					end else if (!cmd.enable_flag && free_found) begin
						present_q[free_idx]  <= 1'b0;
						disabled_q[free_idx] <= 1'b1;
					end
				end
				ebu_pkg::OP_CLEAR_ALL: begin
					present_q  <= '0;
					disabled_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// a new address lands in the lowest free slot
	always_ff @(posedge clk) begin
		if (fire && !found && free_found &&
			((cmd.opcode == ebu_pkg::OP_ADD) ||
			((cmd.opcode == ebu_pkg::OP_SET_ENABLE) && !cmd.enable_flag))) begin
			entry_addr_q[free_idx] <= cmd.address;
		end
	end

endmodule

// ===== design/execution_breakpoint_unit.sv =====
// Execution breakpoint unit.
// Command channel cmd (cmd_valid / cmd_stall) carries an opcode, an address and
// an enable flag: check a pc, add / remove / enable / disable a table entry,
// clear the table, set or clear the temporary breakpoint, arm skip-once or
// clear the sticky hit flags. Every command beat yields exactly one result beat
// on res (res_valid / res_stall) with break_now, table_full and the sticky
// hit, hit address and temporary breakpoint status after the command.
// A command beat is registered into cmd_s1 and its result into res_s2, on res.
// Throughput: one beat per cycle while res is not stalled; the table compares
// all 16 entries in parallel against the registered command, and the state it
// leaves is ready for the very next beat.
// Reset clears the table, the temporary breakpoint, skip-once, the hit flags
// and the hit address, and empties both pipeline stages.
// While res is stalled the result register holds; one more command sits in
// the input stage, after which cmd_stall goes high until res drains.
module execution_breakpoint_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  ebu_pkg::ebu_cmd_t  cmd,
	output logic               res_valid,
	input  logic               res_stall,
	output ebu_pkg::ebu_res_t  res
);

	logic                          valid_s1;
	ebu_pkg::ebu_cmd_t             cmd_s1;
	logic                          valid_s2;
	ebu_pkg::ebu_res_t             res_s2;

	logic                          advance;
	logic                          fire;
	ebu_pkg::tbl_stat_t            tstat;
	ebu_pkg::ebu_res_t             res_next;

	logic [ebu_pkg::ADDR_BITS-1:0] temp_addr_q, temp_addr_d;
	logic                          temp_active_q, temp_active_d;
	logic                          temp_reached_q, temp_reached_d;
	logic                          sticky_q, sticky_d;
	logic [ebu_pkg::ADDR_BITS-1:0] last_hit_q, last_hit_d;
	logic                          skip_q, skip_d;
	logic                          brk;

	assign advance   = !valid_s2 || !res_stall;
	assign fire      = valid_s1 && advance;
	assign cmd_stall = valid_s1 && !advance;
	assign res_valid = valid_s2;
	assign res       = res_s2;

	ebu_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.cmd    (cmd_s1),
		.stat   (tstat)
	);

	always_comb begin
		temp_addr_d    = temp_addr_q;
		temp_active_d  = temp_active_q;
		temp_reached_d = temp_reached_q;
		sticky_d       = sticky_q;
		last_hit_d     = last_hit_q;
		skip_d         = skip_q;
		brk            = 1'b0;
		unique case (cmd_s1.opcode)
			ebu_pkg::OP_CHECK: begin
				// temporary breakpoint first, then skip-once, then the table
				priority if (temp_active_q && (cmd_s1.address == temp_addr_q)) begin
					temp_active_d  = 1'b0;
					temp_addr_d    = '0;
					temp_reached_d = 1'b1;
					sticky_d       = 1'b1;
					last_hit_d     = cmd_s1.address;
					brk            = 1'b1;
				end else if (!tstat.any_present) begin
				end else if (skip_q) begin
					skip_d = 1'b0;
				end else if (tstat.hit) begin
					sticky_d   = 1'b1;
					last_hit_d = cmd_s1.address;
					brk        = 1'b1;
				end
			end
			ebu_pkg::OP_REMOVE: begin
				if (last_hit_q == cmd_s1.address) sticky_d = 1'b0;
			end
			ebu_pkg::OP_SET_ENABLE: begin
				if (!cmd_s1.enable_flag && !tstat.full && (last_hit_q == cmd_s1.address))
					sticky_d = 1'b0;
			end
			ebu_pkg::OP_CLEAR_ALL: begin
				sticky_d = 1'b0;
			end
			ebu_pkg::OP_SET_TEMP: begin
				temp_addr_d    = cmd_s1.address;
				temp_active_d  = 1'b1;
				temp_reached_d = 1'b0;
			end
			ebu_pkg::OP_CLEAR_TEMP: begin
				temp_addr_d    = '0;
				temp_active_d  = 1'b0;
				temp_reached_d = 1'b0;
			end
			ebu_pkg::OP_ARM_SKIP: begin
				skip_d = 1'b1;
			end
			ebu_pkg::OP_CLEAR_HITS: begin
				sticky_d       = 1'b0;
				temp_reached_d = 1'b0;
			end
			default: begin
			end
		endcase

		res_next.break_now   = brk;
		res_next.table_full  = tstat.full;
		res_next.hit_flag    = sticky_d;
		res_next.hit_address = last_hit_d;
		res_next.temp_hit    = temp_reached_d;
		res_next.temp_armed  = temp_active_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			temp_addr_q    <= '0;
			temp_active_q  <= 1'b0;
			temp_reached_q <= 1'b0;
			sticky_q       <= 1'b0;
			last_hit_q     <= '0;
			skip_q         <= 1'b0;
		end else begin
			if (!cmd_stall) valid_s1 <= cmd_valid;
			if (advance) valid_s2 <= valid_s1;
			if (fire) begin
				temp_addr_q    <= temp_addr_d;
				temp_active_q  <= temp_active_d;
				temp_reached_q <= temp_reached_d;
				sticky_q       <= sticky_d;
				last_hit_q     <= last_hit_d;
				skip_q         <= skip_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) cmd_s1 <= cmd;
		if (fire) res_s2 <= res_next;
	end

endmodule

// ===== design/ebu_checker.sv =====
`include "execution_breakpoint_unit_assert.svh"

module ebu_port_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_stall,
	input ebu_pkg::ebu_cmd_t  cmd,
	input logic               res_valid,
	input logic               res_stall,
	input ebu_pkg::ebu_res_t  res
);

	// a stalled result beat stays put
	`EBU_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))
	// every break is recorded in the sticky hit
	`EBU_ASSERT_NOW(a_brk_sticky, res_valid && res.break_now, res.hit_flag)
	// a rejected add or disable never breaks
	`EBU_ASSERT_NOW(a_full_nobrk, res_valid && res.table_full, !res.break_now)
	// the temporary breakpoint is disarmed once reached
	`EBU_ASSERT_NOW(a_temp_excl, res_valid, !(res.temp_hit && res.temp_armed))

endmodule

bind execution_breakpoint_unit ebu_port_checker u_ebu_checker (.*);
